// ===== hdl/mms_pkg.sv =====
package mms_pkg;

    localparam int MAX_ROWS  = 4;
    localparam int MAX_INNER = 4;
    localparam int MAX_COLS  = 4;

    localparam int CFG_W   = 3;
    localparam int IDX_W   = 2;
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int ACC_W   = 34;

    localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
    localparam int B_DEPTH = MAX_INNER * MAX_COLS;
    localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

    localparam logic [CFG_W-1:0] ROWS_RESET  = CFG_W'(3);
    localparam logic [CFG_W-1:0] INNER_RESET = CFG_W'(4);
    localparam logic [CFG_W-1:0] COLS_RESET  = CFG_W'(2);

    typedef enum logic [1:0] {
        MODE_LOAD_A  = 2'd0,
        MODE_LOAD_B  = 2'd1,
        MODE_COMPUTE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CFG_ROWS  = 2'd0,
        CFG_INNER = 2'd1,
        CFG_COLS  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // Zero acts as one, anything above the maximum saturates.
    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input int max_size);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (int'(v) > max_size) begin
            r = CFG_W'(max_size);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hdl/matrix_multiply_small.sv =====
// Load transactions are accepted back to back.
// A compute transaction emits rows*cols results; each goes through inner
// memory reads on one port per matrix, the read register, the multiply register
// and the output load, longer while m_ready is low. Loads are taken again after the last.
// Reset (aresetn low, synchronous) returns to idle and sets the sizes to 3/4/2;
// matrix memories keep their contents and read undefined until written.
module matrix_multiply_small
    import mms_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wen,
    input  logic [1:0]              cfg_addr,
    input  logic [CFG_W-1:0]        cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_mode,
    input  logic [IDX_W-1:0]        s_row_index,
    input  logic [IDX_W-1:0]        s_col_index,
    input  logic signed [ELEM_W-1:0] s_element_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [IDX_W-1:0]        m_out_row,
    output logic [IDX_W-1:0]        m_out_col,
    output logic signed [ACC_W-1:0] m_product_value,
    output logic                    m_last_of_run
);

    logic [CFG_W-1:0] rows_reg, inner_reg, cols_reg;
    logic [CFG_W-1:0] nr, nk, nc;

    state_t           state_reg, state_next;
    logic [CFG_W-1:0] r_reg, r_next, c_reg, c_next, k_reg, k_next;
    logic             issue, out_load, last_elem;

    logic [ELEM_W-1:0]        a_mem [A_DEPTH];
    logic [ELEM_W-1:0]        b_mem [B_DEPTH];
    logic [A_AW-1:0]          a_waddr, a_raddr;
    logic [B_AW-1:0]          b_waddr, b_raddr;
    logic                     s_accept, a_we, b_we;
    logic signed [ELEM_W-1:0] a_rdata_reg, b_rdata_reg;

    logic                     rd_valid_reg, rd_first_reg, rd_last_reg;
    logic                     prod_valid_reg, prod_first_reg, prod_last_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, prod_ext;

    logic                     m_valid_reg, m_last_reg;
    logic [IDX_W-1:0]         m_row_reg, m_col_reg;
    logic signed [ACC_W-1:0]  m_value_reg;

    assign nr = clamp_size(rows_reg, MAX_ROWS);
    assign nk = clamp_size(inner_reg, MAX_INNER);
    assign nc = clamp_size(cols_reg, MAX_COLS);

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= ROWS_RESET;
            inner_reg <= INNER_RESET;
            cols_reg  <= COLS_RESET;
        end else if (cfg_wen) begin
            case (cfg_index_t'(cfg_addr))
                CFG_ROWS:  rows_reg  <= cfg_wdata;
                CFG_INNER: inner_reg <= cfg_wdata;
                CFG_COLS:  cols_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    assign a_we = s_accept && (s_mode == MODE_LOAD_A)
                  && ({1'b0, s_row_index} < nr) && ({1'b0, s_col_index} < nk);
    assign b_we = s_accept && (s_mode == MODE_LOAD_B)
                  && ({1'b0, s_row_index} < nk) && ({1'b0, s_col_index} < nc);

    assign a_waddr = A_AW'(int'(s_row_index) * MAX_INNER + int'(s_col_index));
    assign b_waddr = B_AW'(int'(s_row_index) * MAX_COLS + int'(s_col_index));
    assign a_raddr = A_AW'(int'(r_reg) * MAX_INNER + int'(k_reg));
    assign b_raddr = B_AW'(int'(k_reg) * MAX_COLS + int'(c_reg));

    // Loads only happen while idle, so reads never overlap a pending write.
    always_ff @(posedge aclk) begin
        if (a_we) begin
            a_mem[a_waddr] <= s_element_value;
        end
        a_rdata_reg <= a_mem[a_raddr];
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            b_mem[b_waddr] <= s_element_value;
        end
        b_rdata_reg <= b_mem[b_raddr];
    end

    // sequencer
    assign last_elem = (r_reg == nr - CFG_W'(1)) && (c_reg == nc - CFG_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        issue      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_mode == MODE_COMPUTE) begin
                    state_next = ST_ISSUE;
                    r_next     = '0;
                    c_next     = '0;
                    k_next     = '0;
                end
            end
            ST_ISSUE: begin
                issue = 1'b1;
                if (k_reg == nk - CFG_W'(1)) begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + CFG_W'(1);
                end
            end
            ST_DRAIN: begin
                // final product reaches the accumulator at this edge
                if (prod_valid_reg && prod_last_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load = 1'b1;
                    if (last_elem) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_ISSUE;
                        if (c_reg == nc - CFG_W'(1)) begin
                            c_next = '0;
                            r_next = r_reg + CFG_W'(1);
                        end else begin
                            c_next = c_reg + CFG_W'(1);
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // MAC pipeline: read data, product register, accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg   <= issue;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_first_reg   <= (k_reg == '0);
        rd_last_reg    <= (k_reg == nk - CFG_W'(1));
        prod_first_reg <= rd_first_reg;
        prod_last_reg  <= rd_last_reg;
        prod_reg       <= a_rdata_reg * b_rdata_reg;
    end

    assign prod_ext = ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (prod_valid_reg) begin
            acc_reg <= prod_first_reg ? prod_ext : acc_reg + prod_ext;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_row_reg   <= r_reg[IDX_W-1:0];
            m_col_reg   <= c_reg[IDX_W-1:0];
            m_value_reg <= acc_reg;
            m_last_reg  <= last_elem;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_row       = m_row_reg;
    assign m_out_col       = m_col_reg;
    assign m_product_value = m_value_reg;
    assign m_last_of_run   = m_last_reg;

endmodule

// ===== hdl/mms_checker.sv =====
module mms_checker
    import mms_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    cfg_wen,
    input logic [1:0]              cfg_addr,
    input logic [CFG_W-1:0]        cfg_wdata,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic [1:0]              s_mode,
    input logic [IDX_W-1:0]        s_row_index,
    input logic [IDX_W-1:0]        s_col_index,
    input logic signed [ELEM_W-1:0] s_element_value,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [IDX_W-1:0]        m_out_row,
    input logic [IDX_W-1:0]        m_out_col,
    input logic signed [ACC_W-1:0] m_product_value,
    input logic                    m_last_of_run
);

    // a load transaction never produces a result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode != MODE_COMPUTE && !m_valid |=> !m_valid)
        else $error("result appeared after a load");

    // a compute transaction keeps the input side closed
    a_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode == MODE_COMPUTE |=> !s_ready)
        else $error("input open right after compute");

    // reset empties the result register
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_product_value)
            && $stable(m_out_row) && $stable(m_out_col) && $stable(m_last_of_run))
        else $error("stalled result changed");

endmodule

bind matrix_multiply_small mms_checker u_mms_checker (.*);
